### design/fcn_pkg.sv
package fcn_pkg;

   localparam int MaxTaps    = 256;
   localparam int SampleBits = 16;
   localparam int CoefBits   = 16;
   localparam int CountBits  = 9;

   typedef enum logic [1:0] {
      CMD_LOAD_TAP = 2'd0,
      CMD_PUSH     = 2'd1,
      CMD_FLUSH    = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_TAP_COUNT = 1'd0,
      REG_NORMALISE = 1'd1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MAC,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [7:0]              tap_index;
      logic signed [15:0]      coefficient;
      logic signed [SampleBits-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SampleBits-1:0] out_sample;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic dividend_neg;
      logic divisor_neg;
   } div_ctrl_type;

endpackage

### design/fcn_divider.sv
// Restoring divider on magnitudes, one quotient bit per cycle; sign applied at the end
// gives truncation toward zero.
module fcn_divider #(
   parameter int NumBits = 48,
   parameter int DenBits = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fcn_pkg::div_ctrl_type     ctrl,
   input  logic [NumBits-1:0]        dividend_mag,
   input  logic [DenBits-1:0]        divisor_mag,
   output logic                      done,
   output logic signed [NumBits:0]   quotient
);
   localparam int CntBits = $clog2(NumBits + 1);

   logic [NumBits-1:0] quo_ff, quo_in;
   logic [DenBits:0]   rem_ff, rem_in;
   logic [DenBits-1:0] den_ff;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [DenBits:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DenBits-1:0], quo_ff[NumBits-1]};
      if (ctrl.start) begin
         quo_in  = dividend_mag;
         rem_in  = '0;
         cnt_in  = CntBits'(NumBits);
         busy_in = 1'b1;
         neg_in  = ctrl.dividend_neg ^ ctrl.divisor_neg;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      if (ctrl.start) den_ff <= divisor_mag;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
endmodule

### design/fir_convolve_normalise.sv
// Direct-form FIR over a MAX_TAPS-entry tap memory and a MAX_TAPS-entry circular sample
// memory. A tap load leaves the block idle, so loads can follow back to back. A sample push
// or flush steps through used taps, where used is tap_count limited to MAX_TAPS: one tap per
// cycle through the two memory read ports, then a drain of the read and multiply pipeline,
// the output state and the result transfer. When normalisation applies and the tap sum is
// nonzero, a bit-serial divide runs before the output state. A waiting result holds off the
// next input. A history clear zeroes the sample memory entry by entry. After reset a
// clearing pass zeroes both memories before the first item is accepted.
module fir_convolve_normalise #(
   parameter int MAX_TAPS    = fcn_pkg::MaxTaps
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fcn_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output fcn_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [0:0]      csr_index,
   input  logic [fcn_pkg::CountBits-1:0] csr_wdata
);
   localparam int SampleBits = fcn_pkg::SampleBits;
   localparam int AddrBits = $clog2(MAX_TAPS);
   localparam int CntBits  = AddrBits + 1;
   localparam int ProdBits = SampleBits + fcn_pkg::CoefBits;
   localparam int AccBits  = ProdBits + CntBits;
   localparam int GainBits = fcn_pkg::CoefBits + CntBits;

   fcn_pkg::state_type state_ff, state_in;

   logic signed [fcn_pkg::CoefBits-1:0] tap_mem [MAX_TAPS];
   logic signed [SampleBits-1:0]        hist_mem [MAX_TAPS];
   logic signed [fcn_pkg::CoefBits-1:0] tap_rd_ff;
   logic signed [SampleBits-1:0]        hist_rd_ff;

   logic [fcn_pkg::CountBits-1:0] tap_count_ff;
   logic                          norm_ff;
   logic [AddrBits-1:0]           wp_ff, wp_in;
   logic [CntBits-1:0]            idx_ff, idx_in, used_ff, used_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic                          init_ff, init_in;
   logic signed [AccBits-1:0]     acc_ff, acc_in;
   logic signed [GainBits-1:0]    gain_ff, gain_in;
   logic signed [ProdBits-1:0]    prod_ff;
   logic                          prod_valid_ff;
   fcn_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                 tap_we, hist_we;
   logic [AddrBits-1:0]  tap_waddr, hist_waddr, tap_raddr, hist_raddr;
   logic signed [fcn_pkg::CoefBits-1:0] tap_wdata;
   logic signed [SampleBits-1:0]        hist_wdata;

   fcn_pkg::div_ctrl_type div_ctrl;
   logic                  div_done;
   logic signed [AccBits:0] div_q;
   logic [AccBits-1:0]      acc_mag;
   logic [GainBits-1:0]     gain_mag;
   logic signed [AccBits:0] result_q;
   logic signed [AccBits-1:0] shifted;
   logic                    req_fire;

   assign req_ready = (state_ff == fcn_pkg::ST_IDLE) && !init_ff && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= fcn_pkg::CountBits'(256);
         norm_ff      <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            fcn_pkg::REG_TAP_COUNT: tap_count_ff <= csr_wdata;
            fcn_pkg::REG_NORMALISE: norm_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (tap_we) tap_mem[tap_waddr] <= tap_wdata;
      tap_rd_ff <= tap_mem[tap_raddr];
   end
   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      hist_rd_ff <= hist_mem[hist_raddr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcn_pkg::ST_IDLE:
            if (req_fire) begin
               case (req_data.cmd)
                  fcn_pkg::CMD_CLEAR: state_in = fcn_pkg::ST_CLEAR;
                  fcn_pkg::CMD_PUSH, fcn_pkg::CMD_FLUSH: state_in = fcn_pkg::ST_MAC;
                  default: state_in = fcn_pkg::ST_IDLE;
               endcase
            end
         fcn_pkg::ST_CLEAR:
            if (idx_ff == CntBits'(MAX_TAPS - 1)) state_in = fcn_pkg::ST_IDLE;
         fcn_pkg::ST_MAC:
            if (idx_ff >= used_ff && !rd_valid_ff && !prod_valid_ff) begin
               if (norm_ff && gain_ff != '0) state_in = fcn_pkg::ST_DIV;
               else state_in = fcn_pkg::ST_OUT;
            end
         fcn_pkg::ST_DIV:
            if (div_done) state_in = fcn_pkg::ST_OUT;
         fcn_pkg::ST_OUT: state_in = fcn_pkg::ST_IDLE;
         default: state_in = fcn_pkg::ST_IDLE;
      endcase
   end

   assign acc_mag  = acc_ff[AccBits-1] ? AccBits'(-acc_ff) : AccBits'(acc_ff);
   assign gain_mag = gain_ff[GainBits-1] ? GainBits'(-gain_ff) : GainBits'(gain_ff);
   assign shifted  = acc_ff >>> 15;

   fcn_divider #(.NumBits(AccBits), .DenBits(GainBits)) u_div (
      .clock, .reset, .ctrl(div_ctrl), .dividend_mag(acc_mag), .divisor_mag(gain_mag),
      .done(div_done), .quotient(div_q)
   );

   // The sum holds from accumulation end to ST_OUT; the user must hold the mode (not enforced).
   assign result_q = (norm_ff && gain_ff != '0) ? div_q : (AccBits+1)'(shifted);

   always_comb begin
      tap_we      = 1'b0;
      tap_waddr   = AddrBits'(req_data.tap_index);
      tap_wdata   = req_data.coefficient;
      hist_we     = 1'b0;
      hist_waddr  = wp_ff;
      hist_wdata  = (req_data.cmd == fcn_pkg::CMD_PUSH) ? req_data.sample : '0;
      tap_raddr   = idx_ff[AddrBits-1:0];
      hist_raddr  = (CntBits'(wp_ff) >= idx_ff) ? AddrBits'(CntBits'(wp_ff) - idx_ff) :
                    AddrBits'(CntBits'(wp_ff) + CntBits'(MAX_TAPS) - idx_ff);
      wp_in       = wp_ff;
      idx_in      = idx_ff;
      used_in     = used_ff;
      rd_valid_in = 1'b0;
      init_in     = init_ff;
      acc_in      = acc_ff;
      gain_in     = gain_ff;
      div_ctrl    = '0;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (init_ff) begin
         tap_we     = 1'b1;
         tap_waddr  = idx_ff[AddrBits-1:0];
         tap_wdata  = '0;
         hist_we    = 1'b1;
         hist_waddr = idx_ff[AddrBits-1:0];
         hist_wdata = '0;
         idx_in     = idx_ff + 1'b1;
         if (idx_ff == CntBits'(MAX_TAPS - 1)) init_in = 1'b0;
      end

      case (state_ff)
         fcn_pkg::ST_IDLE:
            if (req_fire) begin
               idx_in = '0;
               case (req_data.cmd)
                  fcn_pkg::CMD_LOAD_TAP:
                     tap_we = (32'(req_data.tap_index) < MAX_TAPS);
                  fcn_pkg::CMD_CLEAR: wp_in = '0;
                  default: begin
                     hist_we = 1'b1;
                     used_in = (32'(tap_count_ff) > MAX_TAPS) ?
                               CntBits'(MAX_TAPS) : CntBits'(tap_count_ff);
                     acc_in  = '0;
                     gain_in = '0;
                  end
               endcase
            end
         fcn_pkg::ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = idx_ff[AddrBits-1:0];
            hist_wdata = '0;
            idx_in     = idx_ff + 1'b1;
         end
         fcn_pkg::ST_MAC: begin
            // The newest sample was written at wp on entry, so the reads in this state already see it.
            if (idx_ff < used_ff) begin
               idx_in      = idx_ff + 1'b1;
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff) gain_in = gain_ff + GainBits'(tap_rd_ff);
            if (prod_valid_ff) acc_in = acc_ff + AccBits'(prod_ff);
            if (state_in != fcn_pkg::ST_MAC) begin
               wp_in = (wp_ff == AddrBits'(MAX_TAPS - 1)) ? '0 : wp_ff + 1'b1;
               div_ctrl.start = (state_in == fcn_pkg::ST_DIV);
               div_ctrl.dividend_neg = acc_ff[AccBits-1];
               div_ctrl.divisor_neg  = gain_ff[GainBits-1];
            end
         end
         fcn_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            if (result_q > (AccBits+1)'((2 ** (SampleBits - 1)) - 1)) begin
               rsp_in.out_sample = {1'b0, {(SampleBits-1){1'b1}}};
               rsp_in.saturated  = 1'b1;
            end else if (result_q < -(AccBits+1)'(2 ** (SampleBits - 1))) begin
               rsp_in.out_sample = {1'b1, {(SampleBits-1){1'b0}}};
               rsp_in.saturated  = 1'b1;
            end else begin
               rsp_in.out_sample = SampleBits'(result_q);
               rsp_in.saturated  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fcn_pkg::ST_IDLE;
         wp_ff         <= '0;
         idx_ff        <= '0;
         used_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         init_ff       <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         idx_ff        <= idx_in;
         used_ff       <= used_in;
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= rd_valid_ff && (state_ff == fcn_pkg::ST_MAC);
         init_ff       <= init_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      acc_ff  <= acc_in;
      gain_ff <= gain_in;
      prod_ff <= tap_rd_ff * hist_rd_ff;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != fcn_pkg::ST_IDLE) |-> !req_ready)
      else $error("request accepted while busy");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcn_pkg::ST_OUT) |=> rsp_valid)
      else $error("result not presented");
   a_div_only_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcn_pkg::ST_DIV) |-> (gain_ff != '0))
      else $error("divide by zero gain");
   a_idle_after_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> (state_ff == fcn_pkg::ST_IDLE))
      else $error("work during clearing pass");
endmodule

### tb/fir_convolve_normalise_tb.sv
`timescale 1ns / 1ps

module fir_convolve_normalise_tb;

   localparam int WatchdogLimit = 20000;
   localparam int SettleCycles  = 400;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   fcn_pkg::req_type     req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   fcn_pkg::rsp_type     rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [0:0]           csr_index = '0;
   logic [fcn_pkg::CountBits-1:0] csr_wdata = '0;

   fcn_pkg::req_type pending_reqs[$];
   fcn_pkg::rsp_type expected_samples[$];

   // Filter state as the testbench sees it.
   logic signed [15:0]         model_taps[fcn_pkg::MaxTaps];
   logic signed [fcn_pkg::SampleBits-1:0] model_history[fcn_pkg::MaxTaps];
   int unsigned                model_wp;
   logic [fcn_pkg::CountBits-1:0] model_tap_count;
   logic                       model_normalise;

   int  error_count = 0;
   int  idle_cycles = 0;
   int  gap_left = 0;
   int  burst_left = 1;
   int  ready_mode = 0;
   int  cycle_count = 0;

   fir_convolve_normalise u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic apply_filter_step(input fcn_pkg::req_type item);
      longint acc;
      longint gain;
      longint q;
      int unsigned used;
      fcn_pkg::rsp_type res;
      acc = 0;
      gain = 0;
      case (item.cmd)
         fcn_pkg::CMD_LOAD_TAP: model_taps[item.tap_index] = item.coefficient;
         fcn_pkg::CMD_CLEAR: begin
            for (int i = 0; i < fcn_pkg::MaxTaps; i++) model_history[i] = '0;
            model_wp = 0;
         end
         default: begin
            model_history[model_wp] = (item.cmd == fcn_pkg::CMD_PUSH) ? item.sample : '0;
            used = (model_tap_count > fcn_pkg::MaxTaps) ? fcn_pkg::MaxTaps : model_tap_count;
            for (int j = 0; j < used; j++) begin
               acc += longint'(model_taps[j]) *
                      longint'(model_history[(model_wp + fcn_pkg::MaxTaps - j) %
                                             fcn_pkg::MaxTaps]);
               gain += longint'(model_taps[j]);
            end
            model_wp = (model_wp + 1) % fcn_pkg::MaxTaps;
            if (model_normalise && gain != 0) q = acc / gain;
            else q = acc >>> 15;
            res.saturated = 1'b0;
            if (q > 32767) begin
               q = 32767;
               res.saturated = 1'b1;
            end else if (q < -32768) begin
               q = -32768;
               res.saturated = 1'b1;
            end
            res.out_sample = q[fcn_pkg::SampleBits-1:0];
            expected_samples.push_back(res);
         end
      endcase
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_filter_step(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls on a pattern that depends on the phase.
   always @(posedge clock) begin
      cycle_count++;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ((cycle_count % 11) > 4) || ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      fcn_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_samples.pop_front();
            if (rsp_data.out_sample !== want.out_sample)
               report_mismatch($sformatf("out_sample got %0d want %0d",
                                         rsp_data.out_sample, want.out_sample));
            if (rsp_data.saturated !== want.saturated)
               report_mismatch($sformatf("saturated got %0b want %0b",
                                         rsp_data.saturated, want.saturated));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("fir_convolve_normalise_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Waits until every queued item has gone in and every result has come out.
   task automatic wait_quiet();
      while (pending_reqs.size() > 0 || req_valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input fcn_pkg::reg_index_type idx,
                            input logic [fcn_pkg::CountBits-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == fcn_pkg::REG_TAP_COUNT) model_tap_count = value;
      else model_normalise = value[0];
   endtask

   task automatic queue_item(input fcn_pkg::cmd_type cmd, input logic [7:0] idx,
                             input logic [15:0] coef, input logic [15:0] smp);
      fcn_pkg::req_type item;
      item.cmd = cmd;
      item.tap_index = idx;
      item.coefficient = coef;
      item.sample = smp;
      pending_reqs.push_back(item);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic random_phase(input logic [fcn_pkg::CountBits-1:0] taps, input logic norm,
                               input int n, input bit small_taps);
      int used;
      int r;
      write_csr(fcn_pkg::REG_TAP_COUNT, taps);
      write_csr(fcn_pkg::REG_NORMALISE, fcn_pkg::CountBits'(norm));
      used = (taps > fcn_pkg::MaxTaps) ? fcn_pkg::MaxTaps : taps;
      // Load up to 40 taps, then a random mix of pushes, flushes, loads, clears.
      for (int i = 0; i < used && i < 40; i++)
         queue_item(fcn_pkg::CMD_LOAD_TAP, 8'(i),
                    small_taps ? 16'($urandom_range(0, 3000)) : 16'($urandom()),
                    16'($urandom()));
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 8)
            queue_item(fcn_pkg::CMD_LOAD_TAP, 8'($urandom()), 16'($urandom()),
                       16'($urandom()));
         else if (r < 70)
            queue_item(fcn_pkg::CMD_PUSH, 8'($urandom()), 16'($urandom()), pick_sample());
         else if (r < 95)
            queue_item(fcn_pkg::CMD_FLUSH, 8'($urandom()), 16'($urandom()),
                       16'($urandom()));
         else
            queue_item(fcn_pkg::CMD_CLEAR, 8'($urandom()), 16'($urandom()),
                       16'($urandom()));
      end
      wait_quiet();
   endtask

   initial begin
      for (int i = 0; i < fcn_pkg::MaxTaps; i++) begin
         model_taps[i] = '0;
         model_history[i] = '0;
      end
      model_wp = 0;
      model_tap_count = 9'd256;
      model_normalise = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme taps and samples, every command, zero gain.
      queue_item(fcn_pkg::CMD_FLUSH, 8'h00, 16'h0000, 16'h0000);
      queue_item(fcn_pkg::CMD_LOAD_TAP, 8'd0, 16'h7fff, 16'h0000);
      queue_item(fcn_pkg::CMD_PUSH, 8'hff, 16'hffff, 16'h7fff);
      queue_item(fcn_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h8000);
      queue_item(fcn_pkg::CMD_LOAD_TAP, 8'd255, 16'h8000, 16'hffff);
      queue_item(fcn_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h7fff);
      queue_item(fcn_pkg::CMD_FLUSH, 8'h00, 16'h0000, 16'hffff);
      queue_item(fcn_pkg::CMD_LOAD_TAP, 8'd1, 16'h8000, 16'h0000);
      queue_item(fcn_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h8000);
      queue_item(fcn_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h8000);
      queue_item(fcn_pkg::CMD_CLEAR, 8'hff, 16'hffff, 16'hffff);
      queue_item(fcn_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h1234);
      wait_quiet();
      write_csr(fcn_pkg::REG_TAP_COUNT, 9'd0);
      queue_item(fcn_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h7fff);
      wait_quiet();
      write_csr(fcn_pkg::REG_TAP_COUNT, 9'd511);
      write_csr(fcn_pkg::REG_NORMALISE, 9'd0);
      queue_item(fcn_pkg::CMD_PUSH, 8'h00, 16'h0000, 16'h8000);
      queue_item(fcn_pkg::CMD_FLUSH, 8'h00, 16'h0000, 16'h0000);
      wait_quiet();

      ready_mode = 1;
      random_phase(9'd1, 1'b1, 130, 1'b0);
      ready_mode = 2;
      random_phase(9'd8, 1'b1, 140, 1'b1);
      ready_mode = 0;
      random_phase(9'd3, 1'b0, 130, 1'b0);
      ready_mode = 1;
      random_phase(9'd16, 1'b1, 140, 1'b0);
      ready_mode = 2;
      random_phase(9'd0, 1'b1, 60, 1'b0);
      ready_mode = 1;
      random_phase(9'd32, 1'b0, 130, 1'b1);
      random_phase(9'd256, 1'b1, 100, 1'b1);
      ready_mode = 2;
      random_phase(9'd511, 1'b0, 60, 1'b0);
      ready_mode = 1;
      random_phase(9'd5, 1'b1, 130, 1'b1);

      if (error_count == 0) begin
         $display("fir_convolve_normalise_tb: done, clean");
      end else begin
         $display("fir_convolve_normalise_tb: done, errors");
      end
      $finish;
   end

endmodule

### fir_convolve_normalise.f
design/fcn_pkg.sv
design/fcn_divider.sv
design/fir_convolve_normalise.sv
tb/fir_convolve_normalise_tb.sv
